// ===== hdl/rsfe_pkg.sv =====
// Shared types, constants and helper functions of the servo frame encoder.
package rsfe_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CHAN_W       = 12;
   localparam int FRAME_LEN    = 21;
   localparam int POS_W        = 5;
   localparam int WORD_W       = 11;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

   localparam logic [7:0] HDR_BIND   = 8'hAA;
   localparam logic [7:0] HDR_NORMAL = 8'h55;

   localparam logic signed [CHAN_W-1:0] PULSE_LIMIT  = 12'sd497;
   localparam logic [CHAN_W-1:0]        PULSE_CENTER = 12'd1497;
   localparam logic [CHAN_W-1:0]        MIRROR_SUM   = 12'd3000;

   // Variant codes held in the sub_protocol register.
   localparam logic [2:0] SUB_STANDARD  = 3'd0;
   localparam logic [2:0] SUB_FLAGS_A   = 3'd1;
   localparam logic [2:0] SUB_FLAGS_B   = 3'd2;
   localparam logic [2:0] SUB_SEQUENCED = 3'd3;
   localparam logic [2:0] SUB_MIRROR    = 3'd4;

   // Register indexes on the configuration port.
   localparam logic REG_SUB_PROTOCOL   = 1'b0;
   localparam logic REG_TRANSMITTER_ID = 1'b1;

   localparam logic [3:0] SEQ_LAST = 4'd9;

   typedef logic [FRAME_LEN-1:0][7:0]          frame_type;
   typedef logic [NUM_CHANNELS-1:0][CHAN_W-1:0] chan_bus_type;

   // Halve with truncation toward zero, clamp and move to the pulse center.
   function automatic logic [WORD_W-1:0] pulse_word(input logic [CHAN_W-1:0] raw);
      logic [CHAN_W:0]          adj;
      logic signed [CHAN_W-1:0] half;
      logic signed [CHAN_W-1:0] clamped;
      logic [CHAN_W-1:0]        sum;
      adj  = {raw[CHAN_W-1], raw} + {{CHAN_W{1'b0}}, raw[CHAN_W-1]};
      half = $signed(adj[CHAN_W:1]);
      if (half > PULSE_LIMIT) begin
         clamped = PULSE_LIMIT;
      end else if (half < -PULSE_LIMIT) begin
         clamped = -PULSE_LIMIT;
      end else begin
         clamped = half;
      end
      sum = $unsigned(clamped) + PULSE_CENTER;
      return sum[WORD_W-1:0];
   endfunction

   // Byte 17 of the sequenced variant, selected by the frame counter.
   function automatic logic [7:0] seq_entry(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0: begin
            val = 8'h14;
         end
         4'd1: begin
            val = 8'h31;
         end
         4'd2: begin
            val = 8'h40;
         end
         default: begin
            val = 8'h49;
         end
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/rc_servo_frame_encoder.sv =====
// Top level of the servo frame encoder: register port, front end, queue and back end.
//
// Each word taken on the req_ channel carries eight signed stick channels, eight
// switch bits, a bind flag and a hop slot. For every such word the block sends a
// 21-byte radio frame on the rsp_ channel, one byte per word, positions 0 to 20 in
// order, with rsp_last_byte set on position 20.
// The front end builds the whole frame image in the cycle a word is accepted and
// pushes it into a small queue. The back end drains the head of the queue into an
// output register, so the first byte of a frame passes the queue and then the output
// register, and bytes follow on every cycle that the receiver takes them. Throughput
// is bounded by the single byte-wide output register.
// req_ready stays high while the queue has room, so a new word is taken while the
// previous frame is still being sent. A stalled receiver simply holds the current
// byte; the queue fills and then req_ready drops until it drains.
// The APB port holds sub_protocol at address 0 and transmitter_id at address 4.
// Reset clears both registers, the sequence counter, the queue and the output valid flag.
module rc_servo_frame_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   // Input channel.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [11:0]                req_chan_aileron,
   input  logic [11:0]                req_chan_elevator,
   input  logic [11:0]                req_chan_throttle,
   input  logic [11:0]                req_chan_rudder,
   input  logic [11:0]                req_chan_five,
   input  logic [11:0]                req_chan_six,
   input  logic [11:0]                req_chan_seven,
   input  logic [11:0]                req_chan_eight,
   input  logic [7:0]                 req_switch_bits,
   input  logic                       req_bind_mode,
   input  logic [3:0]                 req_hop_slot,
   // Result channel.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_frame_byte,
   output logic [rsfe_pkg::POS_W-1:0] rsp_byte_position,
   output logic                       rsp_last_byte,
   // Configuration port.
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic [2:0]             sub_ff;
   logic [31:0]            id_ff;
   logic                   cfg_write;
   logic                   accept;
   logic                   queue_full;
   logic                   queue_nonempty;
   logic                   queue_pop;
   rsfe_pkg::chan_bus_type chan;
   rsfe_pkg::frame_type    front_frame;
   rsfe_pkg::frame_type    head_frame;

   // The port never inserts wait states.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   // Address bit 2 picks the register; the low bits are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 3'd0;
         id_ff  <= 32'd0;
      end else if (cfg_write) begin
         unique case (paddr[2])
            rsfe_pkg::REG_SUB_PROTOCOL: begin
               sub_ff <= pwdata[2:0];
            end
            rsfe_pkg::REG_TRANSMITTER_ID: begin
               id_ff <= pwdata;
            end
            default: begin
               sub_ff <= sub_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         rsfe_pkg::REG_SUB_PROTOCOL: begin
            prdata = {29'd0, sub_ff};
         end
         rsfe_pkg::REG_TRANSMITTER_ID: begin
            prdata = id_ff;
         end
         default: begin
            prdata = 32'd0;
         end
      endcase
   end

   // A word is taken whenever the queue can hold its frame.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign chan[0] = req_chan_aileron;
   assign chan[1] = req_chan_elevator;
   assign chan[2] = req_chan_throttle;
   assign chan[3] = req_chan_rudder;
   assign chan[4] = req_chan_five;
   assign chan[5] = req_chan_six;
   assign chan[6] = req_chan_seven;
   assign chan[7] = req_chan_eight;

   rsfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .chan           (chan),
      .switch_bits    (req_switch_bits),
      .bind_mode      (req_bind_mode),
      .hop_slot       (req_hop_slot),
      .sub_protocol   (sub_ff),
      .transmitter_id (id_ff),
      .frame          (front_frame)
   );

   rsfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_frame),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (head_frame),
      .nonempty  (queue_nonempty)
   );

   rsfe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .frame_valid       (queue_nonempty),
      .frame             (head_frame),
      .frame_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_byte     (rsp_last_byte)
   );

endmodule

// ===== hdl/rsfe_front.sv =====
// Front end: turns one accepted input word into a complete 21-byte frame image.
module rsfe_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  rsfe_pkg::chan_bus_type chan,
   input  logic [7:0]             switch_bits,
   input  logic                   bind_mode,
   input  logic [3:0]             hop_slot,
   input  logic [2:0]             sub_protocol,
   input  logic [31:0]            transmitter_id,
   output rsfe_pkg::frame_type    frame
);

   logic [3:0]                    seq_ff;
   logic [3:0]                    seq_in;
   logic [rsfe_pkg::WORD_W-1:0]   words [rsfe_pkg::NUM_CHANNELS];
   logic [rsfe_pkg::CHAN_W-1:0]   mirrored;

   // The counter steps before it is used, so the frame sees the stepped value.
   assign seq_in = (seq_ff >= rsfe_pkg::SEQ_LAST) ? 4'd0 : seq_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 4'd0;
      end else if (accept && (sub_protocol == rsfe_pkg::SUB_SEQUENCED)) begin
         seq_ff <= seq_in;
      end
   end

   always_comb begin
      for (int i = 0; i < rsfe_pkg::NUM_CHANNELS; i++) begin
         words[i] = rsfe_pkg::pulse_word(chan[i]);
      end
      mirrored = rsfe_pkg::MIRROR_SUM - {1'b0, words[1]};
      if (sub_protocol == rsfe_pkg::SUB_MIRROR) begin
         words[1] = mirrored[rsfe_pkg::WORD_W-1:0];
      end
   end

   always_comb begin
      frame    = '0;
      frame[0] = bind_mode ? rsfe_pkg::HDR_BIND : rsfe_pkg::HDR_NORMAL;
      frame[1] = transmitter_id[31:24];
      frame[2] = transmitter_id[23:16];
      frame[3] = transmitter_id[15:8];
      frame[4] = transmitter_id[7:0];
      for (int i = 0; i < rsfe_pkg::NUM_CHANNELS; i++) begin
         frame[5 + 2*i] = words[i][7:0];
         frame[6 + 2*i] = {5'd0, words[i][rsfe_pkg::WORD_W-1:8]};
      end
      unique case (sub_protocol)
         rsfe_pkg::SUB_FLAGS_A: begin
            frame[12] = frame[12] | {2'b00, switch_bits[1], switch_bits[0], 4'h0};
            frame[10] = frame[10] | {switch_bits[2], switch_bits[3], 6'h00};
         end
         rsfe_pkg::SUB_FLAGS_B: begin
            frame[13] = {switch_bits[4], 7'h03};
            frame[14] = {switch_bits[0], switch_bits[1], switch_bits[4], switch_bits[2],
                         switch_bits[5], switch_bits[6], switch_bits[7], switch_bits[3]};
            frame[15] = 8'h10;
            frame[16] = 8'h10;
            frame[17] = 8'hAA;
            frame[18] = 8'hAA;
            frame[19] = 8'h60;
            frame[20] = 8'h02;
         end
         rsfe_pkg::SUB_SEQUENCED: begin
            frame[12] = frame[12] | 8'h20;
            frame[13] = 8'h00;
            frame[14] = {switch_bits[0], switch_bits[1], 6'h00};
            frame[15] = 8'h27;
            frame[16] = 8'h03;
            frame[17] = rsfe_pkg::seq_entry(seq_in);
            frame[18] = (seq_in == 4'd0) ? 8'h02 : 8'h00;
            frame[19] = 8'h00;
            frame[20] = 8'h00;
         end
         rsfe_pkg::SUB_MIRROR: begin
            frame[19] = 8'h00;
            frame[20] = {hop_slot, 4'hA};
         end
         default: begin
            frame[0] = frame[0];
         end
      endcase
   end

endmodule

// ===== hdl/rsfe_queue.sv =====
// Short first-in first-out queue of frame images between the front and back ends.
module rsfe_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rsfe_pkg::frame_type push_data,
   output logic                full,
   input  logic                pop,
   output rsfe_pkg::frame_type pop_data,
   output logic                nonempty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rsfe_pkg::frame_type entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign nonempty = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/rsfe_back.sv =====
// Back end: sends the frame at the head of the queue one byte per word.
module rsfe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       frame_valid,
   input  rsfe_pkg::frame_type        frame,
   output logic                       frame_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_frame_byte,
   output logic [rsfe_pkg::POS_W-1:0] rsp_byte_position,
   output logic                       rsp_last_byte
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [rsfe_pkg::POS_W-1:0] pos_ff;
   logic [rsfe_pkg::POS_W-1:0] pos_in;
   logic [7:0]                 byte_ff;
   logic [rsfe_pkg::POS_W-1:0] out_pos_ff;
   logic                       last_ff;
   logic                       load;
   logic                       at_last;

   // The output register takes a new byte whenever it is empty or being taken.
   assign load      = !valid_ff || rsp_ready;
   assign at_last   = (pos_ff == rsfe_pkg::LAST_POS);
   assign frame_pop = load && frame_valid && at_last;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = frame_valid;
         if (frame_valid) begin
            pos_in = at_last ? '0 : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && frame_valid) begin
         byte_ff    <= frame[pos_ff];
         out_pos_ff <= pos_ff;
         last_ff    <= at_last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_frame_byte    = byte_ff;
   assign rsp_byte_position = out_pos_ff;
   assign rsp_last_byte     = last_ff;

endmodule

// ===== tb/rc_servo_frame_encoder_test.sv =====
// Self-checking testbench of the servo frame encoder with a built-in frame predictor.
module rc_servo_frame_encoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 8;
   // The block is silent this long only if it has hung; a randomly stalled
   // receiver is not expected to hold it off for so long.
   localparam int STALL_LIMIT  = 2000;
   // Cycles granted after the last byte, so that a stray extra byte shows up.
   localparam int DRAIN_CYCLES = 30;
   localparam int REPORT_LIMIT = 10;
   localparam int POS_W        = rsfe_pkg::POS_W;

   // Variant codes that the block must treat as the standard frame.
   localparam logic [2:0] SUB_SPARE_LOW  = 3'd5;
   localparam logic [2:0] SUB_SPARE_HIGH = 3'd7;

   localparam int NUM_PHASES = 8;

   // One stick word as the sender presents it.
   typedef struct {
      rsfe_pkg::chan_bus_type chans;
      logic [7:0]             switches;
      logic                   bind_req;
      logic [3:0]             hop;
   } stick_word_type;

   // One frame byte as the receiver should see it.
   typedef struct packed {
      logic [7:0]       value;
      logic [POS_W-1:0] pos;
      logic             last;
   } frame_byte_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Block inputs, all at known values from time zero.
   logic              req_valid         = 1'b0;
   logic              req_ready;
   logic [11:0]       req_chan_aileron  = '0;
   logic [11:0]       req_chan_elevator = '0;
   logic [11:0]       req_chan_throttle = '0;
   logic [11:0]       req_chan_rudder   = '0;
   logic [11:0]       req_chan_five     = '0;
   logic [11:0]       req_chan_six      = '0;
   logic [11:0]       req_chan_seven    = '0;
   logic [11:0]       req_chan_eight    = '0;
   logic [7:0]        req_switch_bits   = '0;
   logic              req_bind_mode     = 1'b0;
   logic [3:0]        req_hop_slot      = '0;
   logic              rsp_valid;
   logic              rsp_ready         = 1'b0;
   logic [7:0]        rsp_frame_byte;
   logic [POS_W-1:0]  rsp_byte_position;
   logic              rsp_last_byte;
   logic              psel              = 1'b0;
   logic              penable           = 1'b0;
   logic              pwrite            = 1'b0;
   logic [2:0]        paddr             = '0;
   logic [31:0]       pwdata            = '0;
   logic [31:0]       prdata;
   logic              pready;

   rc_servo_frame_encoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_chan_aileron  (req_chan_aileron),
      .req_chan_elevator (req_chan_elevator),
      .req_chan_throttle (req_chan_throttle),
      .req_chan_rudder   (req_chan_rudder),
      .req_chan_five     (req_chan_five),
      .req_chan_six      (req_chan_six),
      .req_chan_seven    (req_chan_seven),
      .req_chan_eight    (req_chan_eight),
      .req_switch_bits   (req_switch_bits),
      .req_bind_mode     (req_bind_mode),
      .req_hop_slot      (req_hop_slot),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_byte     (rsp_last_byte),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Testbench copy of the registers and of the frame counter.
   logic [2:0]  cfg_variant   = rsfe_pkg::SUB_STANDARD;
   logic [31:0] cfg_tx_id     = '0;
   logic [3:0]  seq_count     = '0;

   stick_word_type words_pending[$];
   frame_byte_type frame_bytes_due[$];

   // When set, neither side idles, so the block runs at its full rate.
   logic        no_idle_phase = 1'b0;

   int          mismatch_count = 0;
   int          bytes_checked  = 0;
   int          frames_checked = 0;
   int          words_sent     = 0;
   int          settings_used  = 1;
   int          stall_cycles   = 0;

   stick_word_type next_word;
   frame_byte_type due_byte;

   // Pulse word of one channel: halve toward zero, clamp to the servo range
   // and move to the center. SystemVerilog int division already truncates
   // toward zero, so negative odd values round the right way.
   function automatic int servo_pulse(input logic [11:0] raw);
      int v;
      v = $signed(raw);
      v = v / 2;
      if (v > 497) begin
         v = 497;
      end
      if (v < -497) begin
         v = -497;
      end
      return v + 1497;
   endfunction

   // Builds the frame that the block should send for one accepted word and
   // queues its 21 bytes. The sequenced variant steps the frame counter first.
   task automatic predict_frame(input stick_word_type w);
      logic [7:0] f [rsfe_pkg::FRAME_LEN];
      int         pulse;
      f[0] = w.bind_req ? 8'hAA : 8'h55;
      f[1] = cfg_tx_id[31:24];
      f[2] = cfg_tx_id[23:16];
      f[3] = cfg_tx_id[15:8];
      f[4] = cfg_tx_id[7:0];
      for (int i = 0; i < rsfe_pkg::NUM_CHANNELS; i++) begin
         pulse = servo_pulse(w.chans[i]);
         // The mirrored variant flips the elevator around 1500, half of 3000.
         if (cfg_variant == rsfe_pkg::SUB_MIRROR && i == 1) begin
            pulse = 3000 - pulse;
         end
         f[5 + 2 * i] = pulse[7:0];
         f[6 + 2 * i] = pulse[15:8];
      end
      case (cfg_variant)
         rsfe_pkg::SUB_FLAGS_A: begin
            if (w.switches[0]) f[12] |= 8'h10;
            if (w.switches[1]) f[12] |= 8'h20;
            if (w.switches[2]) f[10] |= 8'h80;
            if (w.switches[3]) f[10] |= 8'h40;
         end
         rsfe_pkg::SUB_FLAGS_B: begin
            f[13] = 8'h03;
            f[14] = 8'h00;
            if (w.switches[0]) f[14] |= 8'h80;
            if (w.switches[1]) f[14] |= 8'h40;
            if (w.switches[2]) f[14] |= 8'h10;
            if (w.switches[3]) f[14] |= 8'h01;
            if (w.switches[4]) begin
               f[13] |= 8'h80;
               f[14] |= 8'h20;
            end
            if (w.switches[5]) f[14] |= 8'h08;
            if (w.switches[6]) f[14] |= 8'h04;
            if (w.switches[7]) f[14] |= 8'h02;
            f[15] = 8'h10;
            f[16] = 8'h10;
            f[17] = 8'hAA;
            f[18] = 8'hAA;
            f[19] = 8'h60;
            f[20] = 8'h02;
         end
         rsfe_pkg::SUB_SEQUENCED: begin
            seq_count = seq_count + 4'd1;
            if (seq_count > rsfe_pkg::SEQ_LAST) begin
               seq_count = '0;
            end
            f[12] |= 8'h20;
            f[13] = 8'h00;
            f[14] = w.switches[0] ? 8'h80 : 8'h00;
            if (w.switches[1]) f[14] |= 8'h40;
            f[15] = 8'h27;
            f[16] = 8'h03;
            case (seq_count)
               4'd0: begin
                  f[17] = 8'h14;
               end
               4'd1: begin
                  f[17] = 8'h31;
               end
               4'd2: begin
                  f[17] = 8'h40;
               end
               default: begin
                  f[17] = 8'h49;
               end
            endcase
            f[18] = (seq_count == 4'd0) ? 8'h02 : 8'h00;
            f[19] = 8'h00;
            f[20] = 8'h00;
         end
         rsfe_pkg::SUB_MIRROR: begin
            f[19] = 8'h00;
            f[20] = {w.hop, 4'hA};
         end
         default: begin
            // Standard frame, also used for the spare variant codes.
         end
      endcase
      for (int i = 0; i < rsfe_pkg::FRAME_LEN; i++) begin
         frame_bytes_due.push_back('{value: f[i], pos: POS_W'(i),
                                     last: (i == rsfe_pkg::FRAME_LEN - 1)});
      end
   endtask

   // Driver. A word is taken at an edge with req_valid and req_ready high;
   // its frame is predicted right there from the payload still on the ports.
   // The next word is loaded only when the port is free, so req_valid gets
   // at most one assignment per edge and never drops while a word waits.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_frame('{chans: {req_chan_eight, req_chan_seven, req_chan_six,
                                    req_chan_five, req_chan_rudder, req_chan_throttle,
                                    req_chan_elevator, req_chan_aileron},
                            switches: req_switch_bits, bind_req: req_bind_mode,
                            hop: req_hop_slot});
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (words_pending.size() > 0 &&
                (no_idle_phase || $urandom_range(99) >= 10)) begin
               next_word = words_pending.pop_front();
               req_chan_aileron  <= next_word.chans[0];
               req_chan_elevator <= next_word.chans[1];
               req_chan_throttle <= next_word.chans[2];
               req_chan_rudder   <= next_word.chans[3];
               req_chan_five     <= next_word.chans[4];
               req_chan_six      <= next_word.chans[5];
               req_chan_seven    <= next_word.chans[6];
               req_chan_eight    <= next_word.chans[7];
               req_switch_bits   <= next_word.switches;
               req_bind_mode     <= next_word.bind_req;
               req_hop_slot      <= next_word.hop;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every byte taken is checked against the oldest byte still due.
   // The receiver then decides at random whether it takes the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("%0t: unexpected byte %02h at position %0d, last %0b",
                           $realtime, rsp_frame_byte, rsp_byte_position, rsp_last_byte);
               end
               mismatch_count++;
            end else begin
               due_byte = frame_bytes_due.pop_front();
               if (rsp_frame_byte !== due_byte.value || rsp_byte_position !== due_byte.pos ||
                   rsp_last_byte !== due_byte.last) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("%0t: expected %02h pos %0d last %0b, got %02h pos %0d last %0b",
                              $realtime, due_byte.value, due_byte.pos, due_byte.last,
                              rsp_frame_byte, rsp_byte_position, rsp_last_byte);
                  end
                  mismatch_count++;
               end
               bytes_checked++;
               if (due_byte.last) begin
                  frames_checked++;
               end
            end
         end
         rsp_ready <= no_idle_phase || ($urandom_range(99) >= 10);
      end
   end

   // Watchdog: the run ends if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("rc_servo_frame_encoder_test NOT OK");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // One register write on the APB port: setup cycle, then access cycle.
   // The mirror is updated once the write edge has passed.
   task automatic write_register(input logic index, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == rsfe_pkg::REG_SUB_PROTOCOL) begin
         cfg_variant = data[2:0];
      end else begin
         cfg_tx_id = data;
      end
   endtask

   // Holds the sender back until every queued word is taken and every byte
   // it caused has arrived. Conditions are sampled on the falling edge, away
   // from the edge at which the driver and monitor update them.
   task automatic wait_until_drained();
      @(negedge clock);
      while (words_pending.size() != 0 || req_valid || frame_bytes_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Random channel value: mostly anywhere in the 12-bit range, sometimes
   // right at the clamp boundary where truncation and clamping meet.
   function automatic logic [11:0] random_channel();
      int mag;
      if ($urandom_range(3) == 0) begin
         mag = $urandom_range(1000, 990);
         return $urandom_range(1) ? 12'(mag) : 12'(-mag);
      end
      return 12'($urandom);
   endfunction

   function automatic stick_word_type random_word();
      stick_word_type w;
      for (int i = 0; i < rsfe_pkg::NUM_CHANNELS; i++) begin
         w.chans[i] = random_channel();
      end
      w.switches = 8'($urandom);
      w.bind_req = 1'($urandom);
      w.hop      = 4'($urandom);
      return w;
   endfunction

   function automatic stick_word_type word_of(input int vals [rsfe_pkg::NUM_CHANNELS],
                                              input logic [7:0] switches,
                                              input logic bind_req, input logic [3:0] hop);
      stick_word_type w;
      for (int i = 0; i < rsfe_pkg::NUM_CHANNELS; i++) begin
         w.chans[i] = 12'(vals[i]);
      end
      w.switches = switches;
      w.bind_req = bind_req;
      w.hop      = hop;
      return w;
   endfunction

   // Stimulus. The first phase runs with the reset values of the registers;
   // later phases each write both registers while the block is idle and then
   // send a burst of words. The variants, two of the spare codes, both extremes of
   // the id and a second sequenced phase (so the counter wraps twice) are all
   // visited. One phase runs with no idling at all.
   initial begin
      logic [2:0]  phase_variant [NUM_PHASES];
      logic [31:0] phase_id [NUM_PHASES];
      phase_variant = '{rsfe_pkg::SUB_FLAGS_A, rsfe_pkg::SUB_FLAGS_B,
                        rsfe_pkg::SUB_SEQUENCED, rsfe_pkg::SUB_MIRROR,
                        SUB_SPARE_LOW, SUB_SPARE_HIGH,
                        rsfe_pkg::SUB_STANDARD, rsfe_pkg::SUB_SEQUENCED};
      phase_id      = '{32'hFFFF_FFFF, $urandom, $urandom, $urandom,
                        $urandom, $urandom, 32'h0000_0000, $urandom};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration: channel extremes, zero, and the values around
      // the clamp edge and odd negatives where rounding toward zero matters.
      words_pending.push_back(word_of('{8{-2048}}, 8'hFF, 1'b1, 4'hF));
      words_pending.push_back(word_of('{8{2047}}, 8'h00, 1'b0, 4'h0));
      words_pending.push_back(word_of('{8{0}}, 8'h5A, 1'b0, 4'h5));
      words_pending.push_back(word_of('{994, 995, 996, -994, -995, -996, 1, -1},
                                      8'hA5, 1'b1, 4'hA));
      words_pending.push_back(word_of('{-1, -2, -3, 3, 2047, -2048, -997, 997},
                                      8'h3C, 1'b0, 4'h3));
      repeat (6) words_pending.push_back(random_word());
      wait_until_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         // Upper bits of the variant write must be ignored by the block.
         write_register(rsfe_pkg::REG_SUB_PROTOCOL,
                        (32'($urandom) & ~32'h7) | 32'(phase_variant[p]));
         write_register(rsfe_pkg::REG_TRANSMITTER_ID, phase_id[p]);
         settings_used++;
         @(negedge clock);
         no_idle_phase = (p == 3);
         words_pending.push_back(word_of('{8{-2048}}, 8'hFF, 1'b1, 4'hF));
         words_pending.push_back(word_of('{8{2047}}, 8'h00, 1'b0, 4'h0));
         repeat (10) words_pending.push_back(random_word());
         wait_until_drained();
         no_idle_phase = 1'b0;
      end

      // Let any stray byte surface before the verdict.
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (frame_bytes_due.size() != 0) begin
         $display("%0d frame bytes never arrived", frame_bytes_due.size());
         mismatch_count++;
      end

      $display("Sent %0d stick words under %0d register settings; checked %0d frames, %0d bytes.",
               words_sent, settings_used, frames_checked, bytes_checked);
      $display("Settings covered every variant, two spare codes and both id extremes; %0d failures.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("rc_servo_frame_encoder_test OK");
      end else begin
         $display("rc_servo_frame_encoder_test NOT OK");
      end
      $finish;
   end

endmodule
